### sv/fate_pkg.sv
package fate_pkg;

    localparam int DATA_W = 32;

    localparam logic [3:0] OP_READ    = 4'd0;
    localparam logic [3:0] OP_WRITE   = 4'd1;
    localparam logic [3:0] OP_LSEARCH = 4'd2;
    localparam logic [3:0] OP_INSERT  = 4'd3;
    localparam logic [3:0] OP_DELAT   = 4'd4;
    localparam logic [3:0] OP_DELNTH  = 4'd5;
    localparam logic [3:0] OP_SORT    = 4'd6;
    localparam logic [3:0] OP_BSEARCH = 4'd7;
    localparam logic [3:0] OP_MIN     = 4'd8;
    localparam logic [3:0] OP_MEDIAN  = 4'd9;
    localparam logic [3:0] OP_SECOND  = 4'd10;
    localparam logic [3:0] OP_ROTATE  = 4'd11;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD      = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    localparam logic [4:0] SIZE_RESET = 5'd16;

    typedef logic signed [DATA_W-1:0] word_t;

endpackage

### sv/fate_ram.sv
module fate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/fixed_array_table_engine_core.sv
// One request at a time; the sequencer does at most one RAM read or write per cycle.
// Sort does one read and one write per compare; binary search, min, median and second
// smallest sort first and then read the sorted array; rotate does k single-place passes
// with k = places mod n.
// The next request is taken once the previous one is finished, while its result waits.
// Reset: array reads as zero (per-entry valid bits), fill count 0, size 16.
module fixed_array_table_engine_core #(
    parameter int CAPACITY = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3:0]                req_type,
    input  logic [3:0]                slot_index,
    input  logic signed [31:0]        data_value,
    input  logic [4:0]                occurrence,
    input  logic [7:0]                shift_places,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        result_value,
    output logic [3:0]                result_index,
    output logic [1:0]                status,
    input  logic                      cfg_we,
    input  logic [4:0]                cfg_wdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = ($clog2(CAPACITY + 1) > 5) ? $clog2(CAPACITY + 1) : 5;
    localparam int SW = CW + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_PR    = 3'd4;
    localparam logic [2:0] ST_POST  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [2:0] P_PICK = 3'd0;
    localparam logic [2:0] P_SRCH = 3'd1;
    localparam logic [2:0] P_DEL  = 3'd2;
    localparam logic [2:0] P_INS  = 3'd3;
    localparam logic [2:0] P_PASS = 3'd4;
    localparam logic [2:0] P_BS   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             ph_reg, ph_next;
    logic [3:0]             op_reg, op_next;
    logic [3:0]             pos_reg, pos_next;
    fate_pkg::word_t        val_reg, val_next;
    logic [4:0]             occ_reg, occ_next;
    logic [7:0]             shf_reg, shf_next;
    logic [4:0]             size_reg;
    logic [4:0]             fill_reg, fill_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          lim_reg, lim_next;
    logic [4:0]             cnt_reg, cnt_next;
    fate_pkg::word_t        hold_reg, hold_next;
    fate_pkg::word_t        first_reg, first_next;
    logic                   need2_reg, need2_next;
    logic                   avg_reg, avg_next;
    logic                   rot_reg, rot_next;
    logic [7:0]             rem_reg, rem_next;
    logic [2:0]             bc_reg, bc_next;
    logic signed [SW-1:0]   lo_reg, lo_next;
    logic signed [SW-1:0]   hi_reg, hi_next;
    fate_pkg::word_t        rv_reg, rv_next;
    logic [3:0]             ri_reg, ri_next;
    logic [1:0]             st_reg, st_next;
    logic                   vq_reg;
    logic [CAPACITY-1:0]    vld_reg;
    logic                   out_valid_reg, out_valid_next;
    fate_pkg::word_t        out_val_reg, out_val_next;
    logic [3:0]             out_idx_reg, out_idx_next;
    logic [1:0]             out_st_reg, out_st_next;

    logic                   we_c;
    logic [AW-1:0]          waddr_c;
    fate_pkg::word_t        wdata_c;
    logic [AW-1:0]          raddr_c;
    logic [31:0]            ram_rdata;
    fate_pkg::word_t        rd_data;

    logic [CW-1:0]          n_c;
    logic [CW-1:0]          nm1_c;
    logic [CW-1:0]          pos_w;
    logic [CW-1:0]          fill_w;
    logic [CW-1:0]          ip1_c;
    logic [CW-1:0]          im1_c;
    logic signed [SW-1:0]   sum_lh;
    logic [CW-1:0]          mid_c;
    logic signed [SW-1:0]   i_s;
    logic [8:0]             modt_c;
    logic signed [32:0]     msum_c;
    logic signed [32:0]     madj_c;
    logic                   swap_c;

    fate_ram #(
        .WIDTH (fate_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we_c),
        .waddr (waddr_c),
        .wdata (wdata_c),
        .raddr (raddr_c),
        .rdata (ram_rdata)
    );

    // Entries never written since reset read as zero
    assign rd_data = vq_reg ? $signed(ram_rdata) : '0;

    always_comb
    begin
        if (size_reg == 5'd0)
        begin
            n_c = CW'(1);
        end
        else if (32'(size_reg) > CAPACITY)
        begin
            n_c = CW'(CAPACITY);
        end
        else
        begin
            n_c = CW'(size_reg);
        end
    end

    assign nm1_c  = n_c - 1'b1;
    assign pos_w  = CW'(pos_reg);
    assign fill_w = CW'(fill_reg);
    assign ip1_c  = i_reg + 1'b1;
    assign im1_c  = i_reg - 1'b1;
    assign sum_lh = lo_reg + hi_reg;
    assign mid_c  = CW'(sum_lh[SW-1:1]);
    assign i_s    = $signed({2'b00, i_reg});
    assign swap_c = rot_reg || (hold_reg > rd_data);
    assign msum_c = 33'(first_reg) + 33'(rd_data);
    assign madj_c = msum_c + $signed({32'd0, msum_c[32]});

    always_comb
    begin
        modt_c = {rem_reg, shf_reg[7]};
        if (modt_c >= 9'(n_c))
        begin
            modt_c = modt_c - 9'(n_c);
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        occ_next   = occ_reg;
        shf_next   = shf_reg;
        fill_next  = fill_reg;
        i_next     = i_reg;
        lim_next   = lim_reg;
        cnt_next   = cnt_reg;
        hold_next  = hold_reg;
        first_next = first_reg;
        need2_next = need2_reg;
        avg_next   = avg_reg;
        rot_next   = rot_reg;
        rem_next   = rem_reg;
        bc_next    = bc_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        rv_next    = rv_reg;
        ri_next    = ri_reg;
        st_next    = st_reg;
        we_c       = 1'b0;
        waddr_c    = '0;
        wdata_c    = '0;
        raddr_c    = '0;
        out_valid_next = out_valid_reg && !out_ready;
        out_val_next   = out_val_reg;
        out_idx_next   = out_idx_reg;
        out_st_next    = out_st_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = req_type;
                    pos_next   = slot_index;
                    val_next   = data_value;
                    occ_next   = occurrence;
                    shf_next   = shift_places;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                rv_next    = '0;
                ri_next    = '0;
                st_next    = fate_pkg::STAT_OK;
                need2_next = 1'b0;
                avg_next   = 1'b0;
                rot_next   = 1'b0;
                i_next     = '0;
                cnt_next   = '0;
                lim_next   = nm1_c;
                case (op_reg)
                    fate_pkg::OP_READ:
                    begin
                        if (pos_w >= n_c)
                        begin
                            st_next    = fate_pkg::STAT_BAD;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ph_next    = P_PICK;
                            i_next     = pos_w;
                            state_next = ST_RD;
                        end
                    end
                    fate_pkg::OP_WRITE:
                    begin
                        if (pos_w >= n_c)
                        begin
                            st_next = fate_pkg::STAT_BAD;
                        end
                        else
                        begin
                            we_c    = 1'b1;
                            waddr_c = pos_w[AW-1:0];
                            wdata_c = val_reg;
                        end
                        state_next = ST_DONE;
                    end
                    fate_pkg::OP_LSEARCH, fate_pkg::OP_DELNTH:
                    begin
                        ph_next    = P_SRCH;
                        st_next    = fate_pkg::STAT_NOTFOUND;
                        state_next = ST_RD;
                    end
                    fate_pkg::OP_INSERT:
                    begin
                        if (pos_w > fill_w || fill_w >= n_c)
                        begin
                            st_next    = fate_pkg::STAT_BAD;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ph_next    = P_INS;
                            i_next     = fill_w;
                            state_next = ST_RD;
                        end
                    end
                    fate_pkg::OP_DELAT:
                    begin
                        if (pos_w >= n_c)
                        begin
                            st_next    = fate_pkg::STAT_BAD;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ph_next    = P_DEL;
                            i_next     = pos_w;
                            state_next = ST_RD;
                        end
                    end
                    fate_pkg::OP_SORT, fate_pkg::OP_BSEARCH, fate_pkg::OP_MIN,
                    fate_pkg::OP_MEDIAN, fate_pkg::OP_SECOND:
                    begin
                        ph_next = P_PASS;
                        if (nm1_c == '0)
                        begin
                            state_next = ST_POST;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end
                    fate_pkg::OP_ROTATE:
                    begin
                        rem_next   = '0;
                        bc_next    = '0;
                        rot_next   = 1'b1;
                        state_next = ST_MOD;
                    end
                    default:
                    begin
                        st_next    = fate_pkg::STAT_BAD;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MOD:
            begin
                // restoring remainder, one bit of the place count per cycle
                rem_next = modt_c[7:0];
                shf_next = {shf_reg[6:0], 1'b0};
                bc_next  = bc_reg + 1'b1;
                if (bc_reg == 3'd7)
                begin
                    if (modt_c == 9'd0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ph_next    = P_PASS;
                        i_next     = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_PR;
                case (ph_reg)
                    P_PICK, P_SRCH:
                    begin
                        raddr_c = i_reg[AW-1:0];
                    end
                    P_DEL:
                    begin
                        if (ip1_c < n_c)
                        begin
                            raddr_c = ip1_c[AW-1:0];
                        end
                        else
                        begin
                            we_c    = 1'b1;
                            waddr_c = nm1_c[AW-1:0];
                            wdata_c = '0;
                            if (fill_reg != 5'd0)
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                    end
                    P_INS:
                    begin
                        if (i_reg > pos_w)
                        begin
                            raddr_c = im1_c[AW-1:0];
                        end
                        else
                        begin
                            we_c       = 1'b1;
                            waddr_c    = pos_w[AW-1:0];
                            wdata_c    = val_reg;
                            fill_next  = fill_reg + 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                    P_PASS:
                    begin
                        if (i_reg <= lim_reg)
                        begin
                            raddr_c = i_reg[AW-1:0];
                        end
                        else
                        begin
                            // close the pass: the carried value lands at the top
                            we_c    = 1'b1;
                            waddr_c = lim_reg[AW-1:0];
                            wdata_c = hold_reg;
                            i_next  = '0;
                            if (rot_reg)
                            begin
                                rem_next   = rem_reg - 1'b1;
                                state_next = (rem_reg == 8'd1) ? ST_DONE : ST_RD;
                            end
                            else
                            begin
                                lim_next   = lim_reg - 1'b1;
                                state_next = (lim_reg == CW'(1)) ? ST_POST : ST_RD;
                            end
                        end
                    end
                    P_BS:
                    begin
                        if (lo_reg <= hi_reg)
                        begin
                            raddr_c = mid_c[AW-1:0];
                            i_next  = mid_c;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PR:
            begin
                state_next = ST_RD;
                case (ph_reg)
                    P_PICK:
                    begin
                        if (need2_reg)
                        begin
                            first_next = rd_data;
                            need2_next = 1'b0;
                            avg_next   = 1'b1;
                            i_next     = ip1_c;
                        end
                        else if (avg_reg)
                        begin
                            rv_next    = madj_c[32:1];
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            rv_next    = rd_data;
                            state_next = ST_DONE;
                        end
                    end
                    P_SRCH:
                    begin
                        if (rd_data == val_reg && op_reg == fate_pkg::OP_LSEARCH)
                        begin
                            ri_next    = i_reg[3:0];
                            st_next    = fate_pkg::STAT_OK;
                            state_next = ST_DONE;
                        end
                        else if (rd_data == val_reg && 5'(cnt_reg + 1'b1) == occ_reg)
                        begin
                            st_next = fate_pkg::STAT_OK;
                            ph_next = P_DEL;
                        end
                        else
                        begin
                            if (rd_data == val_reg)
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                            if (ip1_c >= n_c)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                i_next = ip1_c;
                            end
                        end
                    end
                    P_DEL:
                    begin
                        we_c    = 1'b1;
                        waddr_c = i_reg[AW-1:0];
                        wdata_c = rd_data;
                        i_next  = ip1_c;
                    end
                    P_INS:
                    begin
                        we_c    = 1'b1;
                        waddr_c = i_reg[AW-1:0];
                        wdata_c = rd_data;
                        i_next  = im1_c;
                    end
                    P_PASS:
                    begin
                        if (i_reg == '0)
                        begin
                            hold_next = rd_data;
                        end
                        else
                        begin
                            // keep the larger value moving up; rotation always moves
                            we_c      = 1'b1;
                            waddr_c   = im1_c[AW-1:0];
                            wdata_c   = swap_c ? rd_data : hold_reg;
                            hold_next = swap_c ? hold_reg : rd_data;
                        end
                        i_next = ip1_c;
                    end
                    P_BS:
                    begin
                        if (val_reg == rd_data)
                        begin
                            ri_next    = i_reg[3:0];
                            st_next    = fate_pkg::STAT_OK;
                            state_next = ST_DONE;
                        end
                        else if (val_reg < rd_data)
                        begin
                            hi_next = i_s - 1'b1;
                        end
                        else
                        begin
                            lo_next = i_s + 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_POST:
            begin
                ph_next    = P_PICK;
                state_next = ST_RD;
                case (op_reg)
                    fate_pkg::OP_BSEARCH:
                    begin
                        ph_next = P_BS;
                        lo_next = '0;
                        hi_next = $signed({2'b00, nm1_c});
                        st_next = fate_pkg::STAT_NOTFOUND;
                    end
                    fate_pkg::OP_MIN:
                    begin
                        i_next = '0;
                    end
                    fate_pkg::OP_MEDIAN:
                    begin
                        if (n_c[0] == 1'b0)
                        begin
                            i_next     = (n_c >> 1) - 1'b1;
                            need2_next = 1'b1;
                        end
                        else
                        begin
                            i_next = nm1_c >> 1;
                        end
                    end
                    fate_pkg::OP_SECOND:
                    begin
                        if (n_c < CW'(2))
                        begin
                            st_next    = fate_pkg::STAT_BAD;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            i_next = n_c - CW'(2);
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = rv_reg;
                    out_idx_next   = ri_reg;
                    out_st_next    = st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= fate_pkg::SIZE_RESET;
            fill_reg      <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (we_c)
            begin
                vld_reg[waddr_c] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg      <= ph_next;
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        occ_reg     <= occ_next;
        shf_reg     <= shf_next;
        i_reg       <= i_next;
        lim_reg     <= lim_next;
        cnt_reg     <= cnt_next;
        hold_reg    <= hold_next;
        first_reg   <= first_next;
        need2_reg   <= need2_next;
        avg_reg     <= avg_next;
        rot_reg     <= rot_next;
        rem_reg     <= rem_next;
        bc_reg      <= bc_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        rv_reg      <= rv_next;
        ri_reg      <= ri_next;
        st_reg      <= st_next;
        vq_reg      <= vld_reg[raddr_c];
        out_val_reg <= out_val_next;
        out_idx_reg <= out_idx_next;
        out_st_reg  <= out_st_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_val_reg;
    assign result_index = out_idx_reg;
    assign status       = out_st_reg;

`ifndef NO_ASSERTIONS
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        we_c |-> state_reg != ST_IDLE)
        else $error("array write while idle");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ST_START)
        else $error("accepted request did not start");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= CAPACITY)
        else $error("fill count beyond capacity");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_st_reg != 2'd3)
        else $error("undefined status code");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished result not presented");
`endif

endmodule
